/* design/gcl_pkg.sv */
// shared types, palette tables and divider step for the gradient colormap
package gcl_pkg;

  localparam int NumStages = 7;
  localparam int NumPal    = 5;
  localparam int NumPts    = 9;
  localparam int DivStages = 4;

  localparam logic [2:0] PalGray = 3'd0;

  // control point positions in hundredths
  localparam logic [6:0] PointPos [NumPal][NumPts] = '{
    '{7'd0, 7'd100, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0},
    '{7'd0, 7'd13, 7'd25, 7'd38, 7'd50, 7'd63, 7'd75, 7'd88, 7'd100},
    '{7'd0, 7'd13, 7'd25, 7'd38, 7'd50, 7'd63, 7'd75, 7'd88, 7'd100},
    '{7'd0, 7'd13, 7'd25, 7'd38, 7'd50, 7'd63, 7'd75, 7'd88, 7'd100},
    '{7'd0, 7'd10, 7'd25, 7'd40, 7'd55, 7'd68, 7'd80, 7'd90, 7'd100}
  };

  // control point colors packed as red, green, blue from msb down
  localparam logic [23:0] PointRgb [NumPal][NumPts] = '{
    '{{8'd0, 8'd0, 8'd0}, {8'd255, 8'd255, 8'd255}, 24'd0, 24'd0, 24'd0,
      24'd0, 24'd0, 24'd0, 24'd0},
    '{{8'd68, 8'd1, 8'd84}, {8'd72, 8'd40, 8'd120}, {8'd62, 8'd74, 8'd137},
      {8'd49, 8'd104, 8'd142}, {8'd38, 8'd130, 8'd142}, {8'd31, 8'd158, 8'd137},
      {8'd53, 8'd183, 8'd121}, {8'd109, 8'd205, 8'd89}, {8'd253, 8'd231, 8'd37}},
    '{{8'd0, 8'd0, 8'd4}, {8'd31, 8'd12, 8'd72}, {8'd85, 8'd15, 8'd109},
      {8'd136, 8'd34, 8'd106}, {8'd186, 8'd54, 8'd85}, {8'd227, 8'd89, 8'd51},
      {8'd249, 8'd140, 8'd10}, {8'd249, 8'd201, 8'd45}, {8'd252, 8'd255, 8'd164}},
    '{{8'd48, 8'd18, 8'd59}, {8'd70, 8'd107, 8'd227}, {8'd36, 8'd176, 8'd240},
      {8'd30, 8'd218, 8'd198}, {8'd98, 8'd236, 8'd137}, {8'd183, 8'd228, 8'd68},
      {8'd240, 8'd183, 8'd42}, {8'd240, 8'd105, 8'd33}, {8'd122, 8'd4, 8'd3}},
    '{{8'd0, 8'd0, 8'd0}, {8'd25, 8'd10, 8'd60}, {8'd60, 8'd20, 8'd130},
      {8'd20, 8'd70, 8'd200}, {8'd0, 8'd170, 8'd200}, {8'd0, 8'd200, 8'd100},
      {8'd230, 8'd220, 8'd30}, {8'd245, 8'd140, 8'd20}, {8'd230, 8'd30, 8'd20}}
  };

  // element 2 red, 1 green, 0 blue
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_ctl_t;

  typedef struct packed {
    logic [7:0] level;
    logic [6:0] pa_pos;
    logic [6:0] pb_pos;
    rgb_t       ca;
    rgb_t       cb;
  } seg_t;

  typedef struct packed {
    logic [14:0] num;
    logic [14:0] den;
    rgb_t        ca;
    rgb_t        cb;
  } frac_t;

  typedef struct packed {
    logic [2:0][23:0] rem;
    logic [15:0]      dvs;
    rgb_t             quo;
  } div_t;

  // two restoring division steps, quotient bits hi and hi-1
  function automatic div_t div_pair(input div_t cur, input logic [2:0] hi);
    div_t        nxt;
    logic [23:0] sub;
    logic [2:0]  bpos;
    nxt = cur;
    for (int ch = 0; ch < 3; ch++) begin
      for (int b = 0; b < 2; b++) begin
        bpos = hi - 3'(b);
        sub  = 24'(cur.dvs) << bpos;
        if (nxt.rem[ch] >= sub) begin
          nxt.rem[ch]       = nxt.rem[ch] - sub;
          nxt.quo[ch][bpos] = 1'b1;
        end
      end
    end
    return nxt;
  endfunction

endpackage

/* design/gcl_seg.sv */
// segment search, palette lookup and fraction terms (stages one and two)
module gcl_seg (
  input  logic              clk_i,
  input  gcl_pkg::pipe_ctl_t ctl_i,
  input  logic [7:0]        level_i,
  input  logic [2:0]        pal_i,
  output gcl_pkg::frac_t    frac_o
);

  gcl_pkg::seg_t  seg_d, seg_q;
  gcl_pkg::frac_t frac_d, frac_q;

  logic [2:0]  pal;
  logic [14:0] lvl100;
  logic [3:0]  cnt;
  logic [3:0]  seg_idx;
  logic [3:0]  pa_idx;

  always_comb begin
    pal    = (pal_i >= 3'(gcl_pkg::NumPal)) ? gcl_pkg::PalGray : pal_i;
    lvl100 = 15'(level_i) * 15'd100;
    cnt    = 4'd0;
    // positions rise along a palette, so the count of passed ends is the segment
    for (int j = 1; j < gcl_pkg::NumPts - 1; j++) begin
      if (lvl100 > 15'(gcl_pkg::PointPos[pal][j]) * 15'd255) begin
        cnt = cnt + 4'd1;
      end
    end
    seg_idx = (pal == gcl_pkg::PalGray) ? 4'd1 : cnt + 4'd1;
    pa_idx  = seg_idx - 4'd1;

    seg_d.level  = level_i;
    seg_d.pa_pos = gcl_pkg::PointPos[pal][pa_idx];
    seg_d.pb_pos = gcl_pkg::PointPos[pal][seg_idx];
    seg_d.ca     = gcl_pkg::PointRgb[pal][pa_idx];
    seg_d.cb     = gcl_pkg::PointRgb[pal][seg_idx];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      seg_q <= seg_d;
    end
  end

  always_comb begin
    frac_d.num = 15'(seg_q.level) * 15'd100 - 15'(seg_q.pa_pos) * 15'd255;
    frac_d.den = 15'(seg_q.pb_pos - seg_q.pa_pos) * 15'd255;
    frac_d.ca  = seg_q.ca;
    frac_d.cb  = seg_q.cb;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      frac_q <= frac_d;
    end
  end

  assign frac_o = frac_q;

endmodule

/* design/gcl_mix.sv */
// weighted sum of the end colors and rounding terms (stage three)
module gcl_mix (
  input  logic              clk_i,
  input  gcl_pkg::pipe_ctl_t ctl_i,
  input  gcl_pkg::frac_t    frac_i,
  output gcl_pkg::div_t     div_o
);

  gcl_pkg::div_t div_d, div_q;

  logic [14:0] rest;
  logic [22:0] total [3];

  always_comb begin
    rest = frac_i.den - frac_i.num;
    div_d.dvs = {frac_i.den, 1'b0};
    div_d.quo = '0;
    for (int ch = 0; ch < 3; ch++) begin
      // ca*(den-num) + cb*num, both terms non-negative
      total[ch] = 23'(frac_i.ca[ch]) * 23'(rest) + 23'(frac_i.cb[ch]) * 23'(frac_i.num);
      div_d.rem[ch] = {total[ch], 1'b0} + 24'(frac_i.den);
    end
    // zero-length segment: quotient of start color over one
    if (frac_i.den == 15'd0) begin
      div_d.dvs = 16'd1;
      for (int ch = 0; ch < 3; ch++) begin
        div_d.rem[ch] = 24'(frac_i.ca[ch]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;

endmodule

/* design/gcl_div.sv */
// pipelined restoring divider, two quotient bits per stage (stages four to seven)
module gcl_div (
  input  logic              clk_i,
  input  gcl_pkg::pipe_ctl_t ctl_i,
  input  gcl_pkg::div_t     div_i,
  output gcl_pkg::rgb_t     quo_o
);

  gcl_pkg::div_t stg_q [gcl_pkg::DivStages];

  for (genvar s = 0; s < gcl_pkg::DivStages; s++) begin : g_stage
    gcl_pkg::div_t stg_in;
    gcl_pkg::div_t stg_d;

    if (s == 0) begin : g_first
      assign stg_in = div_i;
    end else begin : g_next
      assign stg_in = stg_q[s-1];
    end

    assign stg_d = gcl_pkg::div_pair(stg_in, 3'(7 - 2 * s));

    always_ff @(posedge clk_i) begin
      if (ctl_i.en[3+s]) begin
        stg_q[s] <= stg_d;
      end
    end
  end

  // quotient is below 256 by construction, so it needs no saturation
  assign quo_o = stg_q[gcl_pkg::DivStages-1].quo;

endmodule

/* design/gradient_colormap_lerp_top.sv */
// top level of the piecewise-linear gradient colormap
//
// usage:
//   input channel: in_valid_i / in_stall_o carry one 8-bit intensity level_i
//   per transfer. output channel: out_valid_o / out_stall_i carry one color
//   (red_o, green_o, blue_o) per transfer, in input order.
//   palette_select sits at byte address 0 of the apb-style port: 0 grayscale,
//   1 viridis, 2 inferno, 3 turbo, 4 thermal, codes 5..7 fall back to
//   grayscale. write it only while no item is in flight.
// pipeline and throughput:
//   seven register stages: segment search and table lookup, fraction terms,
//   weighted sum, then four stages of a restoring divider with two quotient
//   bits each. one level per cycle sustained while out_stall_i stays low; the
//   divider pipeline sets most of the depth.
// stalls:
//   each stage has its own valid bit and loads when it is empty or the next
//   stage moves, so bubbles close up under out_stall_i and in_stall_o rises
//   only once every stage holds an item. nothing is dropped or repeated.
// reset:
//   rst_ni clears all valid bits and sets the palette to grayscale.
module gradient_colormap_lerp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // level input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  level_i,
  // color output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam logic RegPalette = 1'b0;

  // configuration register
  logic [2:0] pal_q, pal_d;
  logic       cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_comb begin
    pal_d = pal_q;
    if (cfg_wr && (paddr_i[2] == RegPalette)) begin
      pal_d = pwdata_i[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= gcl_pkg::PalGray;
    end else begin
      pal_q <= pal_d;
    end
  end

  assign prdata_o = (paddr_i[2] == RegPalette) ? {29'd0, pal_q} : 32'd0;

  // pipeline flow control: a stage loads when empty or when its successor moves
  gcl_pkg::pipe_ctl_t             ctl;
  logic [gcl_pkg::NumStages-1:0]  valid_q, valid_d;
  logic [gcl_pkg::NumStages:0]    en;

  always_comb begin
    en[gcl_pkg::NumStages] = !out_stall_i;
    for (int k = gcl_pkg::NumStages - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    ctl.en = en[gcl_pkg::NumStages-1:0];
  end

  assign in_stall_o = !en[0];

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < gcl_pkg::NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // datapath
  gcl_pkg::frac_t frac;
  gcl_pkg::div_t  div;
  gcl_pkg::rgb_t  quo;

  gcl_seg u_seg (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .level_i (level_i),
    .pal_i   (pal_q),
    .frac_o  (frac)
  );

  gcl_mix u_mix (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .frac_i (frac),
    .div_o  (div)
  );

  gcl_div u_div (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .div_i (div),
    .quo_o (quo)
  );

  assign out_valid_o = valid_q[gcl_pkg::NumStages-1];
  assign red_o       = quo[2];
  assign green_o     = quo[1];
  assign blue_o      = quo[0];

`ifndef SYNTHESIS
  // input stalls only when every stage holds an item
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled with an empty stage");

  // an open output never backs up the input
  a_no_stall_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is open");

  // an accepted level lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted level lost at pipeline entry");
`endif

endmodule
